[hdl/hmb_pkg.sv]
// Package for the hex maze backtracker: sizes, request, status and config codes, beat structs.
// No dependencies.
`default_nettype none
package hmb_pkg;
    localparam int MaxWidth  = 32;
    localparam int MaxHeight = 32;
    localparam int XW = $clog2(MaxWidth);
    localparam int YW = $clog2(MaxHeight);
    localparam int CW = XW + YW;
    localparam int NumCells = MaxWidth * MaxHeight;
    localparam int DW = CW + 1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_CARVE = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_START = 2'd1;
    localparam logic [1:0] ST_DONE     = 2'd2;

    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_START_X = 2'd2;
    localparam logic [1:0] CFG_START_Y = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [15:0] random_word;
    } in_beat_t;

    typedef struct packed {
        logic [4:0] from_x;
        logic [4:0] from_y;
        logic [2:0] carve_dir;
        logic [4:0] to_x;
        logic [4:0] to_y;
        logic       carved;
        logic       last_carve;
        logic [1:0] status;
    } out_beat_t;

    // Opposite direction, (d+3) mod 6.
    function automatic logic [2:0] opposite(input logic [2:0] d);
        return (d >= 3'd3) ? d - 3'd3 : d + 3'd3;
    endfunction
endpackage
`default_nettype wire

[hdl/hex_maze_backtracker_top.sv]
// Hex maze backtracker top level: sequencer, config registers, memories.
// Depends on hmb_pkg, hmb_map_mem and hmb_stack_mem.
// Start beat: the result beat follows a sweep that clears every map cell.
// Carve beat: each popped dead end adds a rescan; flagged carves skip the search.
// One beat at a time: the next is accepted once the result beat has been taken.
// Reset clears control state, sets config to a 32x32 grid from (0,0); start clears the maps.
`default_nettype none
module hex_maze_backtracker_top
    import hmb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_beat_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_beat_t      out_data,
    input  wire logic      cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [5:0] cfg_data
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CLEAR = 13'b0000000000010,
        S_TOPRD = 13'b0000000000100,
        S_TOPWT = 13'b0000000001000,
        S_NBRD  = 13'b0000000010000,
        S_NBCHK = 13'b0000000100000,
        S_MOD   = 13'b0000001000000,
        S_SEL   = 13'b0000010000000,
        S_RDTOP = 13'b0000100000000,
        S_WRTOP = 13'b0001000000000,
        S_RDNB  = 13'b0010000000000,
        S_WRNB  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0] gw_reg, gh_reg;
    logic [4:0] sx_reg, sy_reg;
    logic [5:0] lw_reg, lh_reg;
    logic [DW-1:0] depth_reg, done_reg, total_reg;
    logic started_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] top_reg;
    logic [2:0] dir_reg;
    logic [5:0] free_reg;
    logic [2:0] count_reg;
    logic [15:0] rem_reg;
    logic [15:0] rnd_reg;
    logic [4:0] it_reg;
    logic [2:0] pick_d_reg;
    logic [CW-1:0] nb_reg;
    out_beat_t out_reg;
    logic out_valid_reg;

    // Memory ports.
    logic m_we;
    logic [CW-1:0] m_waddr, m_raddr;
    logic [6:0] m_wdata, m_rdata;
    logic s_we;
    logic [CW-1:0] s_waddr, s_wdata, s_rdata;

    hmb_map_mem u_map (.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata));
    hmb_stack_mem u_stack (.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(depth_reg[CW-1:0] - 1'b1), .rdata(s_rdata));

    // Neighbour of the top cell in direction dir_reg.
    logic [5:0] nx, ny;
    logic nb_in;
    logic [XW-1:0] top_x;
    logic [YW-1:0] top_y;
    always_comb
    begin
        top_x = top_reg[XW-1:0];
        top_y = top_reg[CW-1:XW];
        nx = {1'b0, top_x};
        ny = {1'b0, top_y};
        unique case (dir_reg)
            3'd0: begin nx = nx + 6'd1; ny = ny - 6'd1; end
            3'd1: nx = nx + 6'd1;
            3'd2: ny = ny + 6'd1;
            3'd3: begin nx = nx - 6'd1; ny = ny + 6'd1; end
            3'd4: nx = nx - 6'd1;
            default: ny = ny - 6'd1;
        endcase
        nb_in = (nx < lw_reg) && (ny < lh_reg);
    end

    // Pick the rem_reg-th free direction (at most six, narrow).
    logic [2:0] sel_dir;
    logic [2:0] seen;
    always_comb
    begin
        sel_dir = 3'd0;
        seen = 3'd0;
        for (int d = 0; d < 6; d++)
        begin
            if (free_reg[d])
            begin
                if (seen == rem_reg[2:0])
                begin
                    sel_dir = 3'(d);
                end
                seen = seen + 3'd1;
            end
        end
    end

    logic [5:0] cw_c, ch_c;
    logic [4:0] csx, csy;
    always_comb
    begin
        cw_c = (gw_reg == 6'd0) ? 6'd1 : (gw_reg > 6'(MaxWidth)) ? 6'(MaxWidth) : gw_reg;
        ch_c = (gh_reg == 6'd0) ? 6'd1 : (gh_reg > 6'(MaxHeight)) ? 6'(MaxHeight) : gh_reg;
        csx = ({1'b0, sx_reg} >= cw_c) ? 5'(cw_c - 6'd1) : sx_reg;
        csy = ({1'b0, sy_reg} >= ch_c) ? 5'(ch_c - 6'd1) : sy_reg;
    end

    // Restoring-divide step for random mod count.
    logic [15:0] rem_shift;
    always_comb
    begin
        rem_shift = {rem_reg[14:0], rnd_reg[15]};
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // Memory control.
    always_comb
    begin
        m_we = 1'b0;
        m_waddr = cnt_reg;
        m_wdata = 7'd0;
        m_raddr = top_reg;
        s_we = 1'b0;
        s_waddr = depth_reg[CW-1:0];
        s_wdata = nb_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                // The sweep marks the start cell visited as it passes it.
                m_we = 1'b1;
                m_waddr = cnt_reg;
                if (cnt_reg == {csy, csx})
                begin
                    m_wdata = 7'b1000000;
                end
                if (cnt_reg == CW'(NumCells - 1))
                begin
                    s_we = 1'b1;
                    s_waddr = '0;
                    s_wdata = {csy, csx};
                end
            end
            S_NBRD: m_raddr = {ny[YW-1:0], nx[XW-1:0]};
            S_RDNB: m_raddr = nb_reg;
            S_WRTOP:
            begin
                m_we = 1'b1;
                m_waddr = top_reg;
                m_wdata = {1'b1, m_rdata[5:0] | (6'd1 << pick_d_reg)};
            end
            S_WRNB:
            begin
                m_we = 1'b1;
                m_waddr = nb_reg;
                m_wdata = {1'b1, m_rdata[5:0] | (6'd1 << opposite(pick_d_reg))};
                s_we = (depth_reg < DW'(NumCells));
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    if (in_data.req_type == REQ_START)
                        state_next = S_CLEAR;
                    else if (!started_reg || done_reg >= total_reg)
                        state_next = S_OUT;
                    else
                        state_next = S_TOPRD;
                end
            S_CLEAR: if (cnt_reg == CW'(NumCells - 1)) state_next = S_OUT;
            S_TOPRD: state_next = (depth_reg == '0) ? S_OUT : S_TOPWT;
            S_TOPWT: state_next = S_NBRD;
            S_NBRD:  state_next = S_NBCHK;
            S_NBCHK:
                if (dir_reg == 3'd5)
                    state_next = S_MOD;
                else
                    state_next = S_NBRD;
            S_MOD:
                if (count_reg == 3'd0)
                    state_next = S_TOPRD;
                else if (it_reg == 5'd16)
                    state_next = S_SEL;
            S_SEL:   state_next = S_RDTOP;
            S_RDTOP: state_next = S_WRTOP;
            S_WRTOP: state_next = S_RDNB;
            S_RDNB:  state_next = S_WRNB;
            S_WRNB:  state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gw_reg <= 6'd32;
            gh_reg <= 6'd32;
            sx_reg <= '0;
            sy_reg <= '0;
            lw_reg <= '0;
            lh_reg <= '0;
            depth_reg <= '0;
            done_reg <= '0;
            total_reg <= '0;
            started_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:   gw_reg <= cfg_data;
                    CFG_HEIGHT:  gh_reg <= cfg_data;
                    CFG_START_X: sx_reg <= cfg_data[4:0];
                    CFG_START_Y: sy_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            unique case (state_reg)
                S_IDLE: if (in_fire) cnt_reg <= '0;
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(NumCells - 1))
                    begin
                        lw_reg <= cw_c;
                        lh_reg <= ch_c;
                        depth_reg <= DW'(1);
                        done_reg <= '0;
                        total_reg <= DW'(cw_c * ch_c - 12'd1);
                        started_reg <= 1'b1;
                    end
                end
                S_MOD: if (count_reg == 3'd0) depth_reg <= depth_reg - 1'b1;
                S_WRNB:
                begin
                    if (depth_reg < DW'(NumCells)) depth_reg <= depth_reg + 1'b1;
                    done_reg <= done_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    rnd_reg <= in_data.random_word;
                    out_reg <= '0;
                    if (in_data.req_type == REQ_CARVE)
                    begin
                        if (!started_reg) out_reg.status <= ST_NO_START;
                        else if (done_reg >= total_reg) out_reg.status <= ST_DONE;
                    end
                end
            S_TOPRD:
            begin
                if (depth_reg == '0) out_reg.status <= ST_DONE;
                free_reg <= '0;
                count_reg <= '0;
                dir_reg <= 3'd0;
            end
            S_TOPWT: top_reg <= s_rdata;
            S_NBCHK:
            begin
                if (nb_in && !m_rdata[6])
                begin
                    free_reg[dir_reg] <= 1'b1;
                    count_reg <= count_reg + 3'd1;
                end
                dir_reg <= dir_reg + 3'd1;
                rem_reg <= '0;
                it_reg <= '0;
            end
            S_MOD:
            begin
                // A dead end leaves the random word untouched for the next cell.
                if (count_reg != 3'd0 && it_reg != 5'd16)
                begin
                    rnd_reg <= {rnd_reg[14:0], 1'b0};
                    rem_reg <= (rem_shift >= {13'd0, count_reg}) ?
                        rem_shift - {13'd0, count_reg} : rem_shift;
                    it_reg <= it_reg + 5'd1;
                end
            end
            S_SEL:
            begin
                pick_d_reg <= sel_dir;
                dir_reg <= sel_dir;
            end
            S_RDTOP: nb_reg <= {ny[YW-1:0], nx[XW-1:0]};
            S_WRNB:
            begin
                out_reg.from_x <= 5'(top_x);
                out_reg.from_y <= 5'(top_y);
                out_reg.carve_dir <= pick_d_reg;
                out_reg.to_x <= 5'(nb_reg[XW-1:0]);
                out_reg.to_y <= 5'(nb_reg[CW-1:XW]);
                out_reg.carved <= 1'b1;
                out_reg.last_carve <= (done_reg + 1'b1) == total_reg;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_out_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |=> out_valid) else $error("no result beat");
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(NumCells)) else $error("stack overflow");
    a_carve_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRNB |-> done_reg < total_reg) else $error("extra carve");
`endif
endmodule
`default_nettype wire

[hdl/hmb_map_mem.sv]
// Visited and opening map memory; the top level clears it with a sweep, one cell per cycle.
// Depends on hmb_pkg.
`default_nettype none
module hmb_map_mem
    import hmb_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [CW-1:0] waddr,
    input  wire logic [6:0]    wdata,
    input  wire logic [CW-1:0] raddr,
    output logic      [6:0]    rdata
);
    // Bit 6 is the visited flag, bits 5..0 the open walls.
    logic [6:0] mem [NumCells];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hdl/hmb_stack_mem.sv]
// Path stack memory of cell indexes.
// Depends on hmb_pkg.
`default_nettype none
module hmb_stack_mem
    import hmb_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [CW-1:0] waddr,
    input  wire logic [CW-1:0] wdata,
    input  wire logic [CW-1:0] raddr,
    output logic      [CW-1:0] rdata
);
    logic [CW-1:0] mem [NumCells];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[dv/hex_maze_backtracker_top_tb.sv]
// Self-checking testbench for the hex maze backtracker top level.
// Depends on hmb_pkg and hex_maze_backtracker_top; predicts each carve in-line.
`default_nettype none
module hex_maze_backtracker_top_tb;
    import hmb_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_beat_t in_data;
    logic out_valid;
    logic out_ready;
    out_beat_t out_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [5:0] cfg_data;

    hex_maze_backtracker_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: register copies, latched grid and the maze itself.
    logic [5:0] reg_w, reg_h;
    logic [4:0] reg_sx, reg_sy;
    int unsigned lat_w, lat_h, carve_total, carves_done, stack_depth;
    bit maze_started;
    bit visited[NumCells];
    int unsigned path_stack[NumCells];
    out_beat_t expected_carves[$];

    int mismatches;
    int idle_pct;
    bit rx_hold;
    int quiet_cycles;
    bit timed_out;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Clamp a size register into 1..max.
    function automatic int unsigned fit_size(input logic [5:0] v, input int unsigned max);
        if (v == 0)
            return 1;
        return (v > max) ? max : int'(v);
    endfunction

    // Work out the result of one request and update the maze copy.
    function automatic out_beat_t predict_carve(input in_beat_t req);
        out_beat_t r;
        int dx[6];
        int dy[6];
        int unsigned top, x, y, cnt, pick, sx, sy;
        int nx, ny, d;
        int unsigned nbs[6];
        int dirs[6];
        dx = '{1, 1, 0, -1, -1, 0};
        dy = '{-1, 0, 1, 1, 0, -1};
        r = '0;
        if (req.req_type == REQ_START)
        begin
            foreach (visited[i]) visited[i] = 1'b0;
            lat_w = fit_size(reg_w, MaxWidth);
            lat_h = fit_size(reg_h, MaxHeight);
            sx = (reg_sx >= lat_w) ? lat_w - 1 : int'(reg_sx);
            sy = (reg_sy >= lat_h) ? lat_h - 1 : int'(reg_sy);
            visited[sy * MaxWidth + sx] = 1'b1;
            path_stack[0] = sy * MaxWidth + sx;
            stack_depth = 1;
            carves_done = 0;
            carve_total = lat_w * lat_h - 1;
            maze_started = 1'b1;
            return r;
        end
        if (!maze_started)
        begin
            r.status = ST_NO_START;
            return r;
        end
        if (carves_done >= carve_total)
        begin
            r.status = ST_DONE;
            return r;
        end
        forever
        begin
            if (stack_depth == 0)
            begin
                r.status = ST_DONE;
                return r;
            end
            top = path_stack[stack_depth - 1];
            x = top % MaxWidth;
            y = top / MaxWidth;
            cnt = 0;
            for (d = 0; d < 6; d++)
            begin
                nx = int'(x) + dx[d];
                ny = int'(y) + dy[d];
                if (nx >= 0 && ny >= 0 && nx < int'(lat_w) && ny < int'(lat_h)
                    && !visited[ny * MaxWidth + nx])
                begin
                    nbs[cnt] = ny * MaxWidth + nx;
                    dirs[cnt] = d;
                    cnt++;
                end
            end
            if (cnt == 0)
                stack_depth--;
            else
                break;
        end
        pick = req.random_word % cnt;
        visited[nbs[pick]] = 1'b1;
        if (stack_depth < NumCells)
        begin
            path_stack[stack_depth] = nbs[pick];
            stack_depth++;
        end
        carves_done++;
        r.from_x = 5'(x);
        r.from_y = 5'(y);
        r.carve_dir = 3'(dirs[pick]);
        r.to_x = 5'(nbs[pick] % MaxWidth);
        r.to_y = 5'(nbs[pick] / MaxWidth);
        r.carved = 1'b1;
        r.last_carve = (carves_done == carve_total);
        r.status = ST_OK;
        return r;
    endfunction

    // Send one request beat, predicting its result at acceptance.
    task automatic send_request(input logic kind, input logic [15:0] word);
        in_beat_t b;
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        b.req_type = kind;
        b.random_word = word;
        in_data = b;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_carves = {expected_carves, predict_carve(b)};
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Register write while idle; waits for drained results plus slack first.
    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        while (expected_carves.size() != 0)
            @(negedge clk);
        repeat (2100) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:   reg_w = val;
            CFG_HEIGHT:  reg_h = val;
            CFG_START_X: reg_sx = val[4:0];
            default:     reg_sy = val[4:0];
        endcase
    endtask

    task automatic set_grid(input logic [5:0] w, input logic [5:0] h,
                            input logic [5:0] sx, input logic [5:0] sy);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_START_X, sx);
        write_reg(CFG_START_Y, sy);
    endtask

    // Carves before any start, then start and carve on a single-cell grid.
    task automatic test_special_cases();
        send_request(REQ_CARVE, 16'hFFFF);
        send_request(REQ_CARVE, 16'h0000);
        set_grid(6'd0, 6'd0, 6'd31, 6'd31);
        send_request(REQ_START, 16'h0000);
        send_request(REQ_CARVE, 16'hA5A5);
    endtask

    // Oversize grid clamps, start cell clamps, extreme random words.
    task automatic test_extremes();
        set_grid(6'd63, 6'd2, 6'd31, 6'd31);
        send_request(REQ_START, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            send_request(REQ_CARVE, (i % 2) ? 16'hFFFF : 16'h0000);
        set_grid(6'd3, 6'd3, 6'd1, 6'd1);
        send_request(REQ_START, 16'h5555);
        for (int i = 0; i < 10; i++)
            send_request(REQ_CARVE, 16'hAAAA ^ i[15:0]);
    endtask

    // Full mazes on small grids, random restarts and overrun carves.
    task automatic test_random_mazes();
        int w, h, n;
        for (int m = 0; m < 21; m++)
        begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 6);
            set_grid(6'(w), 6'(h), 6'($urandom_range(0, 7)), 6'($urandom_range(0, 7)));
            send_request(REQ_START, 16'($urandom));
            n = w * h - 1 + $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                send_request(($urandom_range(99) < 3) ? REQ_START : REQ_CARVE,
                             16'($urandom));
        end
    endtask

    // Receiver holds off while the sender keeps offering beats.
    task automatic test_back_pressure();
        set_grid(6'd32, 6'd32, 6'd16, 6'd0);
        send_request(REQ_START, 16'h1234);
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(negedge clk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_request(REQ_CARVE, 16'($urandom));
        join
        idle_pct = 0;
        for (int i = 0; i < 60; i++)
            send_request(REQ_CARVE, 16'($urandom));
        idle_pct = 26;
    endtask

    // Result checker: compares each accepted beat against the oldest prediction.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_carves.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat %p", out_data);
            end
            else
            begin
                want = expected_carves.pop_front();
                if (want.from_x !== out_data.from_x || want.from_y !== out_data.from_y
                    || want.carve_dir !== out_data.carve_dir || want.to_x !== out_data.to_x
                    || want.to_y !== out_data.to_y || want.carved !== out_data.carved
                    || want.last_carve !== out_data.last_carve
                    || want.status !== out_data.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
    end

    // Receiver stall pattern, changed at the falling edge.
    always @(negedge clk)
        out_ready <= !rx_hold && ($urandom_range(99) >= idle_pct);

    // Watchdog on cycles with no accepted beat.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 100000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        out_ready = 1'b0;
        rx_hold = 1'b0;
        idle_pct = 26;
        mismatches = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        maze_started = 1'b0;
        reg_w = 6'd32;
        reg_h = 6'd32;
        reg_sx = '0;
        reg_sy = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_special_cases();
        test_extremes();
        test_random_mazes();
        test_back_pressure();
        while (expected_carves.size() != 0)
            @(negedge clk);
        repeat (2100) @(negedge clk);
        if (mismatches == 0 && expected_carves.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

[hex_maze_backtracker_top.f]
hdl/hmb_pkg.sv
hdl/hmb_map_mem.sv
hdl/hmb_stack_mem.sv
hdl/hex_maze_backtracker_top.sv
dv/hex_maze_backtracker_top_tb.sv
